[hdl/pp_pkg.sv]
// shared types and constants for the perspective projection block
package pp_pkg;

   localparam int FRAC_BITS_DEF = 6;

   localparam int COORD_W = 16;
   localparam int VIEW_W  = 9;
   localparam int CSR_AW  = 2;

   localparam logic [VIEW_W-1:0]  VIEW_WIDTH_RST      = 9'd256;
   localparam logic [VIEW_W-1:0]  VIEW_HEIGHT_RST     = 9'd160;
   localparam logic [COORD_W-1:0] CAMERA_DISTANCE_RST = 16'd12800;
   localparam logic               OUTPUT_FORMAT_RST   = 1'b0;

   typedef enum logic [CSR_AW-1:0] {
      CSR_VIEW_WIDTH      = 2'd0,
      CSR_VIEW_HEIGHT     = 2'd1,
      CSR_CAMERA_DISTANCE = 2'd2,
      CSR_OUTPUT_FORMAT   = 2'd3
   } csr_index_type;

   typedef enum logic {
      FMT_INTEGER = 1'b0,
      FMT_FIXED   = 1'b1
   } out_format_type;

   typedef struct packed {
      logic [VIEW_W-1:0] view_width;
      logic [VIEW_W-1:0] view_height;
      out_format_type    output_format;
   } view_cfg_type;

endpackage

[hdl/pp_divider.sv]
// pipelined signed restoring divider, one quotient bit per stage, with sideband
module pp_divider #(
   parameter int FRAC_BITS = pp_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [15:0]        in_num,
   input  logic signed [15:0]        in_den,
   input  logic        [SIDE_W-1:0]  in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [15:0]        out_quo,
   output logic                      out_zero,
   output logic        [SIDE_W-1:0]  out_side
);

   localparam int QW = 16 + FRAC_BITS;

   logic [QW+1:0]     valid_ff;
   logic [QW+2:0]     rdy;

   logic [15:0]       rem_ff  [0:QW];
   logic [QW-1:0]     quo_ff  [0:QW];
   logic [15:0]       den_ff  [0:QW];
   logic              neg_ff  [0:QW];
   logic              zero_ff [0:QW];
   logic [SIDE_W-1:0] side_ff [0:QW+1];

   logic signed [15:0] q_ff;
   logic               qzero_ff;

   logic [15:0] num_abs;
   logic [15:0] den_abs;

   assign num_abs = in_num[15] ? 16'(-in_num) : 16'(in_num);
   assign den_abs = in_den[15] ? 16'(-in_den) : 16'(in_den);

   assign rdy[QW+2] = out_ready;
   assign in_ready  = rdy[0];

   genvar s;
   generate
      for (s = 0; s <= QW + 1; s++) begin : g_rdy
         assign rdy[s] = !valid_ff[s] || rdy[s+1];
      end
   endgenerate

   // operand conditioning
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= {num_abs, {FRAC_BITS{1'b0}}};
         den_ff[0]  <= den_abs;
         neg_ff[0]  <= in_num[15] ^ in_den[15];
         zero_ff[0] <= (in_den == 16'sd0);
         side_ff[0] <= in_side;
      end
   end

   // one restoring step per stage
   generate
      for (s = 1; s <= QW; s++) begin : g_step
         logic [16:0]   trial;
         logic [16:0]   diff;
         logic          fits;
         logic [15:0]   rem_in;
         logic [QW-1:0] quo_in;

         assign trial  = {rem_ff[s-1], quo_ff[s-1][QW-1]};
         assign diff   = trial - {1'b0, den_ff[s-1]};
         assign fits   = trial >= {1'b0, den_ff[s-1]};
         assign rem_in = fits ? diff[15:0] : trial[15:0];
         assign quo_in = {quo_ff[s-1][QW-2:0], fits};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (rdy[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[s]) begin
               rem_ff[s]  <= rem_in;
               quo_ff[s]  <= quo_in;
               den_ff[s]  <= den_ff[s-1];
               neg_ff[s]  <= neg_ff[s-1];
               zero_ff[s] <= zero_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   endgenerate

   // sign fix, quotient wraps to 16 bits
   logic [15:0] q_in;
   assign q_in = neg_ff[QW] ? 16'(-quo_ff[QW][15:0]) : quo_ff[QW][15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[QW+1] <= 1'b0;
      end else if (rdy[QW+1]) begin
         valid_ff[QW+1] <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[QW+1]) begin
         q_ff          <= signed'(q_in);
         qzero_ff      <= zero_ff[QW];
         side_ff[QW+1] <= side_ff[QW];
      end
   end

   assign out_valid = valid_ff[QW+1];
   assign out_quo   = q_ff;
   assign out_zero  = qzero_ff;
   assign out_side  = side_ff[QW+1];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff[QW] && !zero_ff[QW] |-> rem_ff[QW] < den_ff[QW])
      else $error("divider remainder not below divisor");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[QW] && !rdy[QW+1] |=> valid_ff[QW])
      else $error("divider dropped a stalled request");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && den_ff[0] == 16'd0 |-> zero_ff[0])
      else $error("zero divisor not flagged");

endmodule

[hdl/pp_mapper.sv]
// scale by quotient and offset to the screen centre, two register stages
module pp_mapper #(
   parameter int FRAC_BITS = pp_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pp_pkg::view_cfg_type cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [15:0]  in_quo,
   input  logic                in_zero,
   input  logic signed [15:0]  in_x,
   input  logic signed [15:0]  in_y,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [15:0]  out_x,
   output logic signed [15:0]  out_y,
   output logic                out_last
);

   logic               valid_a_ff;
   logic signed [31:0] prod_x_ff;
   logic signed [31:0] prod_y_ff;
   logic               zero_a_ff;
   logic               last_a_ff;

   logic               out_valid_ff;
   logic signed [15:0] out_x_ff;
   logic signed [15:0] out_y_ff;
   logic               out_last_ff;

   logic rdy_a;
   logic rdy_b;

   assign rdy_b    = !out_valid_ff || out_ready;
   assign rdy_a    = !valid_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // products
   logic signed [15:0] half_x;
   logic signed [31:0] prod_x_in;
   logic signed [31:0] prod_y_in;

   assign half_x    = in_x >>> 1;
   assign prod_x_in = half_x * in_quo;
   assign prod_y_in = in_y * in_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (rdy_a) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         zero_a_ff <= in_zero;
         last_a_ff <= in_last;
      end
   end

   // centre offset and format selection
   logic signed [15:0] px;
   logic signed [15:0] py;
   logic [22:0]        wide_w;
   logic [22:0]        wide_h;
   logic signed [15:0] cx_fix;
   logic signed [15:0] cy_fix;
   logic signed [15:0] cx_int;
   logic signed [15:0] cy_int;
   logic signed [15:0] minus_one;
   logic signed [15:0] x_in;
   logic signed [15:0] y_in;

   assign px     = prod_x_ff[FRAC_BITS+15:FRAC_BITS];
   assign py     = prod_y_ff[FRAC_BITS+15:FRAC_BITS];
   assign wide_w = 23'(cfg.view_width) << FRAC_BITS;
   assign wide_h = 23'(cfg.view_height) << FRAC_BITS;
   assign cx_fix = signed'(wide_w[15:0]) >>> 1;
   assign cy_fix = signed'(wide_h[15:0]) >>> 1;
   assign cx_int = signed'({8'd0, cfg.view_width[8:1]});
   assign cy_int = signed'({8'd0, cfg.view_height[8:1]});

   always_comb begin
      if (cfg.output_format == pp_pkg::FMT_FIXED) begin
         minus_one = signed'({{(16-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}});
         x_in      = cx_fix + px;
         y_in      = cy_fix - py;
      end else begin
         minus_one = -16'sd1;
         x_in      = cx_int + (px >>> FRAC_BITS);
         y_in      = cy_int - (py >>> FRAC_BITS);
      end
      if (zero_a_ff) begin
         x_in = minus_one;
         y_in = minus_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy_b) begin
         out_valid_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         out_x_ff    <= x_in;
         out_y_ff    <= y_in;
         out_last_ff <= last_a_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_last  = out_last_ff;

   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff && rdy_b |=> out_valid_ff)
      else $error("product stage request not moved to output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff && !rdy_b |=> valid_a_ff && $stable(prod_x_ff))
      else $error("product stage lost a stalled request");

   a_zero_int: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff && rdy_b && zero_a_ff && cfg.output_format == pp_pkg::FMT_INTEGER
      |=> out_x_ff == -16'sd1 && out_y_ff == -16'sd1)
      else $error("zero depth not mapped to minus one");

endmodule

[hdl/perspective_projection.sv]
// top level: the divider pipeline feeds the mapper, which holds the output register
// throughput one vertex per cycle when not stalled; one quotient bit per divider stage
// a stalled output holds the pipeline, empty stages still take new requests
// synchronous active-high reset clears all valid bits and loads register defaults
// configuration writes are never stalled, csr_ready is always high
module perspective_projection #(
   parameter int FRAC_BITS = pp_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vertex_x, vertex_y, vertex_z
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // screen_x, screen_y
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_data
);

   localparam int SIDE_W = 2 * pp_pkg::COORD_W + 1;

   logic [8:0]              view_width_ff;
   logic [8:0]              view_height_ff;
   logic signed [15:0]      camera_distance_ff;
   pp_pkg::out_format_type  output_format_ff;
   pp_pkg::view_cfg_type    view_cfg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff      <= pp_pkg::VIEW_WIDTH_RST;
         view_height_ff     <= pp_pkg::VIEW_HEIGHT_RST;
         camera_distance_ff <= signed'(pp_pkg::CAMERA_DISTANCE_RST);
         output_format_ff   <= pp_pkg::out_format_type'(pp_pkg::OUTPUT_FORMAT_RST);
      end else if (csr_valid && csr_ready) begin
         case (pp_pkg::csr_index_type'(csr_addr))
            pp_pkg::CSR_VIEW_WIDTH: begin
               view_width_ff <= csr_data[8:0];
            end
            pp_pkg::CSR_VIEW_HEIGHT: begin
               view_height_ff <= csr_data[8:0];
            end
            pp_pkg::CSR_CAMERA_DISTANCE: begin
               camera_distance_ff <= signed'(csr_data);
            end
            pp_pkg::CSR_OUTPUT_FORMAT: begin
               output_format_ff <= pp_pkg::out_format_type'(csr_data[0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign view_cfg.view_width    = view_width_ff;
   assign view_cfg.view_height   = view_height_ff;
   assign view_cfg.output_format = output_format_ff;

   logic [SIDE_W-1:0]  div_side_in;
   logic               div_valid;
   logic               div_ready;
   logic signed [15:0] div_quo;
   logic               div_zero;
   logic [SIDE_W-1:0]  div_side;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;

   assign div_side_in = {req_tlast, req_tdata[31:16], req_tdata[15:0]};

   pp_divider #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_num    (camera_distance_ff),
      .in_den    (signed'(req_tdata[47:32])),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_quo   (div_quo),
      .out_zero  (div_zero),
      .out_side  (div_side)
   );

   pp_mapper #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mapper (
      .clock     (clock),
      .reset     (reset),
      .cfg       (view_cfg),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_quo    (div_quo),
      .in_zero   (div_zero),
      .in_x      (signed'(div_side[15:0])),
      .in_y      (signed'(div_side[31:16])),
      .in_last   (div_side[32]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (screen_x),
      .out_y     (screen_y),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {screen_y, screen_x};

endmodule

[tb/tb.sv]
// self-checking testbench for the perspective projection block
module tb;

   localparam int FRAC_BITS    = pp_pkg::FRAC_BITS_DEF;
   localparam int PIPE_LATENCY = FRAC_BITS + 19;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 235;
   localparam longint TIMEOUT  = 4000000;

   typedef struct {
      logic [15:0] screen_x;
      logic [15:0] screen_y;
      logic        last;
   } projection_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_data   = '0;

   // shadow copy of the view registers
   logic [pp_pkg::VIEW_W-1:0]         view_width      = pp_pkg::VIEW_WIDTH_RST;
   logic [pp_pkg::VIEW_W-1:0]         view_height     = pp_pkg::VIEW_HEIGHT_RST;
   logic signed [pp_pkg::COORD_W-1:0] camera_distance = pp_pkg::CAMERA_DISTANCE_RST;
   pp_pkg::out_format_type            output_format   =
      pp_pkg::out_format_type'(pp_pkg::OUTPUT_FORMAT_RST);

   logic source_stalls = 1'b0;
   logic sink_stalls   = 1'b0;
   int   error_count   = 0;

   projection_type expected_projections[$];

   perspective_projection #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
   endfunction

   function automatic longint fixed_mul(longint a, longint b);
      return wrap16((a * b) >>> FRAC_BITS);
   endfunction

   function automatic projection_type project_vertex(logic [15:0] vx, logic [15:0] vy,
                                                     logic [15:0] vz, logic last);
      longint x, y, z, one, scale, px, py, rx, ry, cx, cy;
      projection_type r;
      x   = wrap16(vx);
      y   = wrap16(vy);
      z   = wrap16(vz);
      one = longint'(1) << FRAC_BITS;
      if (z != 0) begin
         scale = wrap16((longint'(camera_distance) * one) / z);
         px    = fixed_mul(x >>> 1, scale);
         py    = fixed_mul(y, scale);
         if (output_format == pp_pkg::FMT_FIXED) begin
            cx = wrap16(longint'(view_width) * one) >>> 1;
            cy = wrap16(longint'(view_height) * one) >>> 1;
            rx = cx + px;
            ry = cy - py;
         end else begin
            rx = longint'(view_width >> 1) + (px >>> FRAC_BITS);
            ry = longint'(view_height >> 1) - (py >>> FRAC_BITS);
         end
      end else begin
         rx = (output_format == pp_pkg::FMT_FIXED) ? -one : -1;
         ry = rx;
      end
      r.screen_x = rx[15:0];
      r.screen_y = ry[15:0];
      r.last     = last;
      return r;
   endfunction

   function automatic logic [15:0] random_coord();
      logic [15:0] edges [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
      case ($urandom_range(0, 9))
         0: begin
            return edges[$urandom_range(0, 4)];
         end
         1, 2: begin
            return 16'($urandom_range(0, 1023) - 512);
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   function automatic logic [15:0] random_depth();
      if ($urandom_range(0, 19) == 0) begin
         return 16'h0000;
      end
      return random_coord();
   endfunction

   // response side: random back-pressure and in-order checking
   always @(posedge clock) begin
      rsp_tready <= !(sink_stalls && $urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_projections.size() == 0) begin
            $error("unexpected response: screen_x %0d screen_y %0d",
                   $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]));
            error_count++;
         end else begin
            want = expected_projections.pop_front();
            if (rsp_tdata[15:0] !== want.screen_x) begin
               $error("screen_x: expected %0d, got %0d",
                      $signed(want.screen_x), $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.screen_y) begin
               $error("screen_y: expected %0d, got %0d",
                      $signed(want.screen_y), $signed(rsp_tdata[31:16]));
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] vz, input logic last);
      while (source_stalls && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vy, vx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      expected_projections.push_back(project_vertex(vx, vy, vz, last));
   endtask

   // stop sending, then let every outstanding request come back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_projections.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_csr(input pp_pkg::csr_index_type index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pp_pkg::CSR_VIEW_WIDTH: begin
            view_width = value[pp_pkg::VIEW_W-1:0];
         end
         pp_pkg::CSR_VIEW_HEIGHT: begin
            view_height = value[pp_pkg::VIEW_W-1:0];
         end
         pp_pkg::CSR_CAMERA_DISTANCE: begin
            camera_distance = value;
         end
         pp_pkg::CSR_OUTPUT_FORMAT: begin
            output_format = pp_pkg::out_format_type'(value[0]);
         end
         default: begin
         end
      endcase
   endtask

   task automatic configure_view(input logic [8:0] w, input logic [8:0] h,
                                 input logic [15:0] cam_distance,
                                 input pp_pkg::out_format_type fmt);
      write_csr(pp_pkg::CSR_VIEW_WIDTH, {7'd0, w});
      write_csr(pp_pkg::CSR_VIEW_HEIGHT, {7'd0, h});
      write_csr(pp_pkg::CSR_CAMERA_DISTANCE, cam_distance);
      write_csr(pp_pkg::CSR_OUTPUT_FORMAT, {15'd0, fmt});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_vertex(16'd0, 16'd0, 16'd64, 1'b0);
      send_vertex(16'd64, -16'sd64, 16'd64, 1'b1);
      send_vertex(16'd0, 16'd0, 16'd0, 1'b1);
      send_vertex(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
      send_vertex(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
      send_vertex(16'd100, -16'sd100, 16'h8000, 1'b0);
      send_vertex(-16'sd100, 16'd100, 16'h7FFF, 1'b1);
      drain_pipeline();
   endtask

   task automatic test_register_extremes();
      configure_view(9'd511, 9'd0, 16'h7FFF, pp_pkg::FMT_FIXED);
      send_vertex(16'd0, 16'd0, 16'd0, 1'b1);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h0001, 1'b0);
      send_vertex(16'h8000, 16'h8000, 16'hFFFF, 1'b1);
      send_vertex(16'h0001, 16'hFFFF, 16'h0002, 1'b0);
      drain_pipeline();
      configure_view(9'd0, 9'd511, 16'h8000, pp_pkg::FMT_INTEGER);
      send_vertex(16'h7FFF, 16'h8000, 16'h0001, 1'b1);
      send_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      send_vertex(16'hFFFF, 16'h0001, 16'h7FFF, 1'b1);
      send_vertex(16'd0, 16'd0, 16'd0, 1'b0);
      drain_pipeline();
      configure_view(9'd1, 9'd1, 16'd0, pp_pkg::FMT_FIXED);
      send_vertex(16'd1234, -16'sd1234, 16'd5, 1'b1);
      drain_pipeline();
   endtask

   task automatic test_random_projection();
      logic [15:0] distance;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               configure_view(9'd511, 9'd511, 16'h7FFF, pp_pkg::FMT_FIXED);
            end
            1: begin
               configure_view(9'd0, 9'd0, 16'h8000, pp_pkg::FMT_INTEGER);
            end
            2: begin
               configure_view(pp_pkg::VIEW_WIDTH_RST, pp_pkg::VIEW_HEIGHT_RST,
                              pp_pkg::CAMERA_DISTANCE_RST, pp_pkg::FMT_INTEGER);
            end
            default: begin
               distance = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023) - 512)
                                                      : 16'($urandom);
               configure_view(9'($urandom), 9'($urandom), distance,
                              pp_pkg::out_format_type'($urandom_range(0, 1)));
            end
         endcase
         // first phase runs flat out on both sides
         source_stalls <= (phase != 0);
         sink_stalls   <= (phase != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_vertex(random_coord(), random_coord(), random_depth(),
                        $urandom_range(0, 7) == 0);
         end
         drain_pipeline();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_projection();
      if (error_count == 0) begin
         $display("** perspective_projection: PASSED **");
      end else begin
         $display("** perspective_projection: FAILED **");
      end
      $finish;
   end

   initial begin
      #TIMEOUT;
      $display("** perspective_projection: FAILED **");
      $finish;
   end

endmodule

[sim.f]
hdl/pp_pkg.sv
hdl/pp_divider.sv
hdl/pp_mapper.sv
hdl/perspective_projection.sv
tb/tb.sv
